[sv/ceb_pkg.sv]
`default_nettype none
package ceb_pkg;

  // Input item opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIT_PERIOD = 2'd0,
    REG_HIGH_LEVEL = 2'd1
  } cfg_reg_t;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned LEVEL_W    = 7;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd38;
  localparam logic [LEVEL_W-1:0]  LEVEL_RESET  = 7'd90;

  // Output clip and offset-binary conversion
  localparam int unsigned CLIP_MAX   = 127;
  localparam logic [7:0]  SAMPLE_OFS = 8'h80;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] sample;
    logic       sample_valid;
    logic       load_refused;
    logic       busy_res;
  } out_item_t;

  // Bit timer status toward the top level, valid in the accept cycle
  typedef struct packed {
    logic [LEVEL_W-1:0] drive;
    logic               refused;
    logic               busy;
  } timer_res_t;

endpackage
`default_nettype wire

[sv/cassette_bit_audio_encoder.sv]
`default_nettype none
// Cassette bit audio encoder.
// Input channel (in_valid/in_stall/in_data): a load item (op 0) hands over
// one byte to send MSB first; a tick item (op 1) asks for one audio sample.
// Every item gives exactly one result on the output channel
// (out_valid/out_stall/out_data): the filtered sample on ticks, status only
// on loads. A load while a byte is still being sent is refused and flagged.
// Configuration: cfg_we with cfg_index and cfg_wdata writes the half-cycle
// length (index 0) or the drive level (index 1). The user must write only
// while idle; the block itself does not enforce this.
// Timing: one item at a time. A load's result goes through the holding
// register into the output register; a tick's result waits for the serial
// multiplier, which walks one coefficient bit per cycle, once for the
// low-pass and once for the high-pass stage.
// A finished result waits in a holding register while the output register
// is stalled; in_stall stays high from a transfer until its result has
// moved into the output register.
// Synchronous reset: encoder idle, filters at zero, registers at 38 and 90.
module cassette_bit_audio_encoder #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire ceb_pkg::in_item_t              in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output ceb_pkg::out_item_t                  out_data,
  input  wire logic                           cfg_we,
  input  wire logic [ceb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ceb_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ceb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_FILT = 3'b010,
    S_HOLD = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [PERIOD_W-1:0] period_r;
  logic [LEVEL_W-1:0]  level_r;
  out_item_t           res_r, out_r;
  logic                out_valid_r;
  logic                in_accept;
  logic                out_free;
  logic                filt_start, filt_done;
  logic [7:0]          filt_sample;
  timer_res_t          tres;

  assign in_stall   = (state_r != S_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign filt_start = in_accept && (in_data.op == OP_TICK);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
      level_r  <= LEVEL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BIT_PERIOD: period_r <= cfg_wdata[PERIOD_W-1:0];
        REG_HIGH_LEVEL: level_r  <= cfg_wdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // item sequencing
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = (in_data.op == OP_TICK) ? S_FILT : S_HOLD;
        end
      end
      S_FILT: begin
        if (filt_done) begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_HOLD && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // holding and output registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_r.sample       <= '0;
      res_r.sample_valid <= (in_data.op == OP_TICK);
      res_r.load_refused <= tres.refused;
      res_r.busy_res     <= tres.busy;
    end else if (state_r == S_FILT && filt_done) begin
      res_r.sample <= filt_sample;
    end
    if (state_r == S_HOLD && out_free) begin
      out_r <= res_r;
    end
  end

  ceb_bit_timer u_timer (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .item       (in_data),
    .bit_period (period_r),
    .high_level (level_r),
    .res        (tres)
  );

  ceb_filter #(
    .FRAC_BITS (FRAC_BITS)
  ) u_filter (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (filt_start),
    .drive  (tres.drive),
    .done   (filt_done),
    .sample (filt_sample)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

[sv/ceb_serial_mul.sv]
`default_nettype none
// Shift-add multiplier: one coefficient bit per cycle, LSB first.
// Result is floor(operand * coef / 2^NB).
module ceb_serial_mul #(
  parameter int unsigned W  = 25,
  parameter int unsigned NB = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic signed [W-1:0] operand,
  input  wire logic [NB-1:0]       coef,
  output logic                     done,
  output logic signed [W-1:0]      prod
);

  localparam int unsigned CW = $clog2(NB + 1);

  logic signed [W:0]   acc_r, acc_nxt, sum;
  logic signed [W-1:0] opnd_r;
  logic [NB-1:0]       coef_r;
  logic [CW-1:0]       cnt_r;
  logic                busy_r;
  logic                done_r;

  // add the selected partial product, then drop one bit (floor)
  assign sum     = acc_r + (coef_r[0] ? {opnd_r[W-1], opnd_r} : '0);
  assign acc_nxt = sum >>> 1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(NB - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r  <= '0;
      opnd_r <= operand;
      coef_r <= coef;
    end else if (busy_r) begin
      acc_r  <= acc_nxt;
      coef_r <= coef_r >> 1;
    end
  end

  assign done = done_r;
  assign prod = acc_r[W-1:0];

endmodule
`default_nettype wire

[sv/ceb_filter.sv]
`default_nettype none
// Low-pass then high-pass stage, sharing one serial multiplier.
// The sample is taken from the accumulators before the update.
module ceb_filter #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [ceb_pkg::LEVEL_W-1:0] drive,
  output logic                             done,
  output logic [7:0]                       sample
);
  import ceb_pkg::*;

  localparam int unsigned AW = FRAC_BITS + 9;
  localparam longint unsigned KL_L =
    ((64'd5577 << FRAC_BITS) + 64'd5000) / 64'd10000;
  localparam longint unsigned KH_L =
    ((64'd70984 << FRAC_BITS) + 64'd5000000) / 64'd10000000;
  localparam logic [FRAC_BITS-1:0] KL = KL_L[FRAC_BITS-1:0];
  localparam logic [FRAC_BITS-1:0] KH = KH_L[FRAC_BITS-1:0];
  localparam longint unsigned CLIP_L = 64'(CLIP_MAX) << FRAC_BITS;
  localparam logic signed [AW:0] CLIP_HI = CLIP_L[AW:0];
  localparam logic signed [AW:0] CLIP_LO = -CLIP_HI;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_LP   = 3'b010,
    F_HP   = 3'b100
  } fstate_t;

  fstate_t state_r, state_nxt;

  logic signed [AW-1:0] lp_r, hp_r, lp_new;
  logic signed [AW-1:0] x_fix;
  logic signed [AW:0]   d;
  logic [AW:0]          mag;
  logic [6:0]           ipart;
  logic [7:0]           v;
  logic [7:0]           sample_r;
  logic                 mul_start, mul_done;
  logic signed [AW-1:0] mul_opnd, mul_prod;
  logic [FRAC_BITS-1:0] mul_coef;

  // output value from current accumulators: clip, truncate toward zero
  assign d     = {lp_r[AW-1], lp_r} - {hp_r[AW-1], hp_r};
  assign mag   = d[AW] ? -d : d;
  assign ipart = mag[FRAC_BITS +: 7];
  always_comb begin
    if (d >= CLIP_HI) begin
      v = 8'(CLIP_MAX);
    end else if (d < CLIP_LO) begin
      v = -8'(CLIP_MAX);
    end else if (d[AW]) begin
      v = -{1'b0, ipart};
    end else begin
      v = {1'b0, ipart};
    end
  end

  assign x_fix  = signed'({2'b00, drive, {FRAC_BITS{1'b0}}});
  assign lp_new = lp_r + mul_prod;

  // multiplier launch: low-pass on start, high-pass when low-pass is done
  always_comb begin
    state_nxt = state_r;
    mul_start = 1'b0;
    mul_opnd  = x_fix - lp_r;
    mul_coef  = KL;
    case (state_r)
      F_IDLE: begin
        if (start) begin
          mul_start = 1'b1;
          state_nxt = F_LP;
        end
      end
      F_LP: begin
        mul_opnd = lp_new - hp_r;
        mul_coef = KH;
        if (mul_done) begin
          mul_start = 1'b1;
          state_nxt = F_HP;
        end
      end
      F_HP: begin
        if (mul_done) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      lp_r    <= '0;
      hp_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == F_LP && mul_done) begin
        lp_r <= lp_new;
      end
      if (state_r == F_HP && mul_done) begin
        hp_r <= hp_r + mul_prod;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == F_IDLE && start) begin
      sample_r <= v ^ SAMPLE_OFS;
    end
  end

  ceb_serial_mul #(
    .W  (AW),
    .NB (FRAC_BITS)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .operand (mul_opnd),
    .coef    (mul_coef),
    .done    (mul_done),
    .prod    (mul_prod)
  );

  assign done   = (state_r == F_HP) && mul_done;
  assign sample = sample_r;

endmodule
`default_nettype wire

[sv/ceb_bit_timer.sv]
`default_nettype none
// Byte shifter and half-cycle timing; updates on each accepted item.
module ceb_bit_timer (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         accept,
  input  wire ceb_pkg::in_item_t            item,
  input  wire logic [ceb_pkg::PERIOD_W-1:0] bit_period,
  input  wire logic [ceb_pkg::LEVEL_W-1:0]  high_level,
  output ceb_pkg::timer_res_t               res
);
  import ceb_pkg::*;

  logic [7:0]          shift_r, shift_nxt;
  logic [3:0]          bits_left_r, bits_left_nxt;
  logic                second_r, second_nxt;
  logic [PERIOD_W-1:0] count_r, count_nxt;
  logic                level_r, level_nxt;

  logic                active;
  logic                bit_now;
  logic [PERIOD_W-1:0] period_raw, period;
  logic [PERIOD_W:0]   cnt;

  assign active     = (bits_left_r != 4'd0);
  assign bit_now    = shift_r[7];
  assign period_raw = bit_now ? {1'b0, bit_period[PERIOD_W-1:1]} : bit_period;
  assign period     = (period_raw == '0) ? PERIOD_W'(1) : period_raw;
  assign cnt        = {1'b0, count_r} + 1'b1;

  always_comb begin
    shift_nxt     = shift_r;
    bits_left_nxt = bits_left_r;
    second_nxt    = second_r;
    count_nxt     = count_r;
    level_nxt     = level_r;
    if (accept) begin
      if (item.op == OP_LOAD) begin
        if (!active) begin
          shift_nxt     = item.data_byte;
          bits_left_nxt = 4'd8;
          count_nxt     = '0;
          second_nxt    = 1'b0;
        end
      end else if (active) begin
        if (cnt >= {1'b0, period}) begin
          // half-cycle ends
          level_nxt = ~level_r;
          count_nxt = '0;
          if (bit_now && !second_r) begin
            second_nxt = 1'b1;
          end else begin
            second_nxt    = 1'b0;
            shift_nxt     = {shift_r[6:0], 1'b0};
            bits_left_nxt = bits_left_r - 4'd1;
          end
        end else begin
          count_nxt = cnt[PERIOD_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r     <= '0;
      bits_left_r <= '0;
      second_r    <= 1'b0;
      count_r     <= '0;
      level_r     <= 1'b0;
    end else begin
      shift_r     <= shift_nxt;
      bits_left_r <= bits_left_nxt;
      second_r    <= second_nxt;
      count_r     <= count_nxt;
      level_r     <= level_nxt;
    end
  end

  assign res.drive   = (active && !level_r) ? high_level : '0;
  assign res.refused = (item.op == OP_LOAD) && active;
  assign res.busy    = (bits_left_nxt != 4'd0);

endmodule
`default_nettype wire

[test/ceb_audio_monitor.sv]
module ceb_audio_monitor
  import ceb_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned           mismatches,
  output int unsigned           outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // Filter coefficients: 0.5577 and 0.0070984, rounded to FRAC_BITS fraction bits
  localparam longint UNITY   = longint'(1) <<< FRAC_BITS;
  localparam longint LP_COEF = ((longint'(5577) <<< FRAC_BITS) + 5000) / 10000;
  localparam longint HP_COEF = ((longint'(70984) <<< FRAC_BITS) + 5000000) / 10000000;
  localparam longint CLIP    = longint'(CLIP_MAX);

  // Register copies
  logic [PERIOD_W-1:0] period_reg;
  logic [LEVEL_W-1:0]  level_reg;

  // Encoder state
  logic [7:0]          shift_reg;
  logic [3:0]          bits_to_send;
  logic                second_half;
  logic [PERIOD_W-1:0] half_count;
  logic                drive_level;
  longint              lp_acc;
  longint              hp_acc;

  out_item_t awaited_samples[$];

  initial mismatches = 0;
  initial outstanding = 0;

  // One filter step: output from the old accumulators, then update both stages
  function automatic logic [7:0] tape_filter(input logic [LEVEL_W-1:0] drive);
    longint diff;
    longint clipped;
    longint x;
    diff = lp_acc - hp_acc;
    x = longint'(drive) * UNITY;
    if (diff >= CLIP * UNITY) begin
      clipped = CLIP;
    end else if (diff < -CLIP * UNITY) begin
      clipped = -CLIP;
    end else if (diff >= 0) begin
      clipped = diff >>> FRAC_BITS;
    end else begin
      clipped = -((-diff) >>> FRAC_BITS);
    end
    // arithmetic shift of a signed product is a floor divide
    lp_acc = lp_acc + (((x - lp_acc) * LP_COEF) >>> FRAC_BITS);
    hp_acc = hp_acc + (((lp_acc - hp_acc) * HP_COEF) >>> FRAC_BITS);
    return clipped[7:0] ^ SAMPLE_OFS;
  endfunction

  // Expected result of one input transfer; advances the encoder state
  function automatic out_item_t encode_transfer(input in_item_t item);
    out_item_t         res;
    logic              bit_now;
    logic [PERIOD_W:0] half_len;
    logic [PERIOD_W:0] next_count;
    res = '0;
    if (item.op == OP_LOAD) begin
      if (bits_to_send != 0) begin
        res.load_refused = 1'b1;
      end else begin
        // drive level carries over from the previous byte
        shift_reg    = item.data_byte;
        bits_to_send = 4'd8;
        half_count   = '0;
        second_half  = 1'b0;
      end
    end else begin
      res.sample_valid = 1'b1;
      if (bits_to_send != 0) begin
        bit_now = shift_reg[7];
        // one bits use two half-cycles of half the period
        half_len = bit_now ? {2'b00, period_reg[PERIOD_W-1:1]} : {1'b0, period_reg};
        if (half_len == 0) begin
          half_len = 1;
        end
        res.sample = tape_filter(drive_level ? '0 : level_reg);
        next_count = {1'b0, half_count} + 1'b1;
        if (next_count >= half_len) begin
          drive_level = ~drive_level;
          half_count  = '0;
          if (bit_now && !second_half) begin
            second_half = 1'b1;
          end else begin
            second_half  = 1'b0;
            shift_reg    = shift_reg << 1;
            bits_to_send = bits_to_send - 1'b1;
          end
        end else begin
          half_count = next_count[PERIOD_W-1:0];
        end
      end else begin
        // idle: silence through the filter
        res.sample = tape_filter('0);
      end
    end
    res.busy_res = (bits_to_send != 0);
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    logic      bad;
    if (!rst_n) begin
      period_reg   = PERIOD_RESET;
      level_reg    = LEVEL_RESET;
      shift_reg    = '0;
      bits_to_send = '0;
      second_half  = 1'b0;
      half_count   = '0;
      drive_level  = 1'b0;
      lp_acc       = 0;
      hp_acc       = 0;
      awaited_samples.delete();
    end else begin
      // register writes; bits above the register width drop out
      if (cfg_we) begin
        if (cfg_index == REG_BIT_PERIOD) begin
          period_reg = cfg_wdata[PERIOD_W-1:0];
        end else if (cfg_index == REG_HIGH_LEVEL) begin
          level_reg = cfg_wdata[LEVEL_W-1:0];
        end
      end

      // result transfer against the oldest expectation
      if (out_valid && !out_stall) begin
        if (awaited_samples.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: result with nothing expected: sample %02h valid %0b refused %0b busy %0b",
                     $realtime, out_data.sample, out_data.sample_valid,
                     out_data.load_refused, out_data.busy_res);
          end
          mismatches = mismatches + 1;
        end else begin
          want = awaited_samples.pop_front();
          bad = (out_data.sample !== want.sample) ||
                (out_data.sample_valid !== want.sample_valid) ||
                (out_data.load_refused !== want.load_refused) ||
                (out_data.busy_res !== want.busy_res);
          if (bad) begin
            if (mismatches < 10) begin
              $display("%0t: mismatch: expected sample %02h valid %0b refused %0b busy %0b",
                       $realtime, want.sample, want.sample_valid, want.load_refused,
                       want.busy_res);
              $display("%0t:           got      sample %02h valid %0b refused %0b busy %0b",
                       $realtime, out_data.sample, out_data.sample_valid,
                       out_data.load_refused, out_data.busy_res);
            end
            mismatches = mismatches + 1;
          end
        end
      end

      // input transfer
      if (in_valid && !in_stall) begin
        awaited_samples.push_back(encode_transfer(in_data));
      end
    end
    outstanding <= awaited_samples.size();
  end

endmodule

[test/tb_cassette_bit_audio_encoder.sv]
module tb_cassette_bit_audio_encoder;
  timeunit 1ns;
  timeprecision 1ps;
  import ceb_pkg::*;

  localparam int unsigned FRAC = 16;

  // Indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_BIT_PERIOD;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  bit                    steady = 1'b0;
  int unsigned           mismatches;
  int unsigned           outstanding;

  cassette_bit_audio_encoder #(.FRAC_BITS(FRAC)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  ceb_audio_monitor #(.FRAC_BITS(FRAC)) audio_mon (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Run limit, far above the slowest correct run
  initial begin
    #(20ms);
    $display("Test completed with failures");
    $finish;
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 24);
  end

  // One input transfer, with a random gap in front now and then
  task automatic send_op(input logic op, input logic [7:0] value);
    int unsigned gap;
    if (!steady && $urandom_range(99) < 24) begin
      gap = $urandom_range(1, 37);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{op: op, data_byte: value};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Hold off until every expected result has come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Back-to-back register writes, optionally hitting the unused indexes too
  task automatic program_regs(input logic [15:0] period_word, input logic [15:0] level_word,
                              input bit stray);
    cfg_we    <= 1'b1;
    cfg_index <= REG_BIT_PERIOD;
    cfg_wdata <= period_word;
    @(posedge clk);
    if (stray) begin
      cfg_index <= REG_SPARE_2;
      cfg_wdata <= 16'hFFFF;
      @(posedge clk);
      cfg_index <= REG_SPARE_3;
      cfg_wdata <= 16'h0000;
      @(posedge clk);
    end
    cfg_index <= REG_HIGH_LEVEL;
    cfg_wdata <= level_word;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly ticks; loads sparse enough that most bytes play out in full
  task automatic run_phase(input int unsigned count, input int unsigned load_pct);
    for (int unsigned k = 0; k < count; k++) begin
      if ($urandom_range(99) < load_pct) begin
        send_op(OP_LOAD, 8'($urandom));
      end else begin
        send_op(OP_TICK, 8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: period 2, full level with junk in the upper data bits
    program_regs(16'd2, 16'hFF7F, 1'b0);
    send_op(OP_TICK, 8'h00);
    send_op(OP_LOAD, 8'hFF);
    send_op(OP_LOAD, 8'h00);          // refused, byte in flight
    repeat (16) send_op(OP_TICK, 8'hFF);
    send_op(OP_LOAD, 8'hA5);          // idle again, taken
    send_op(OP_TICK, 8'h00);
    send_op(OP_LOAD, 8'h3C);          // refused
    send_op(OP_TICK, 8'h00);
    settle();

    program_regs(16'd3, 16'd90, 1'b0);
    run_phase(150, 6);
    settle();

    // period 0: every half-cycle collapses to one sample; level 0
    program_regs(16'd0, 16'd0, 1'b0);
    run_phase(80, 8);
    settle();

    // period 1: one bits get a zero half length
    program_regs(16'd1, 16'd105, 1'b1);
    run_phase(80, 8);
    settle();

    // no idling on either side
    program_regs(16'd5, 16'd127, 1'b0);
    steady <= 1'b1;
    run_phase(150, 3);
    settle();
    steady <= 1'b0;

    // longest period: a half-cycle that never ends within the phase
    program_regs(16'hFFFF, 16'd64, 1'b0);
    send_op(OP_LOAD, 8'h5A);
    run_phase(60, 2);
    settle();

    // period shrinks under a half-cycle in progress
    program_regs(16'd2, 16'd33, 1'b1);
    run_phase(120, 6);
    settle();

    program_regs(PERIOD_RESET, LEVEL_RESET, 1'b0);
    run_phase(160, 1);

    settle();
    repeat (80) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
